[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int COPY    = (ROWS - 1) * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] KIND_RESET  = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_SCROLL = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    typedef struct packed {
        logic       accept;
        logic       do_put;
        logic       do_set;
        logic       do_read;
        logic       do_clear;
        logic       sweep_start;
        logic [1:0] sweep_kind;
        logic       sweep_en;
        logic       load_out;
    } t_dp_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       will_scroll;
        logic       sweep_last;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: an 80 x 25 store of color/character cells and a
// cursor, driven by put-character, set-cursor, read-cell and clear requests.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Contents
//  s_*       in   i_s_tvalid/o_s_tready  tuser: cmd; tdata: char, row, col
//  m_*       out  o_m_tvalid/i_m_tready  tdata: cursor, position, entry, flag
//  cfg_*     in   i_cfg_wr_en            text color attribute
//
//  Put character and set cursor pass through IDLE and EXEC; read cell also passes through RWAIT.
//  A scroll or a clear sweeps all 2000 cells through the single write
//  port of the store.
//  After reset a clearing pass fills the store with blanks in color 7;
//  no request is taken meanwhile.
//  A request is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // char_code[7:0], target_row[12:8], target_col[19:13]
    input  wire  [1:0]  i_s_tuser,   // cmd[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata    // cursor_row[4:0], cursor_col[11:5],
                                     // cursor_position[22:12], read_entry[38:23],
                                     // scrolled[39]
);
    import tcw_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    tcw_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (i_s_tuser),
        .i_char_code   (i_s_tdata[7:0]),
        .i_target_row  (i_s_tdata[12:8]),
        .i_target_col  (i_s_tdata[19:13]),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .o_result      (o_m_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: request intake, command dispatch,
// store sweeps and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    input  wire tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_ctl o_ctl
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_RWAIT = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_ctl.sweep_en = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    unique case (i_sts.cmd)
                        CMD_PUT: begin
                            o_ctl.do_put = 1'b1;
                            if (i_sts.will_scroll) begin
                                o_ctl.sweep_start = 1'b1;
                                o_ctl.sweep_kind  = KIND_SCROLL;
                                n_state           = ST_SWEEP;
                            end else begin
                                o_ctl.load_out = 1'b1;
                                n_state        = ST_IDLE;
                            end
                        end
                        CMD_SET: begin
                            o_ctl.do_set   = 1'b1;
                            o_ctl.load_out = 1'b1;
                            n_state        = ST_IDLE;
                        end
                        CMD_READ: begin
                            o_ctl.do_read = 1'b1;
                            n_state       = ST_RWAIT;
                        end
                        CMD_CLEAR: begin
                            o_ctl.do_clear    = 1'b1;
                            o_ctl.sweep_start = 1'b1;
                            o_ctl.sweep_kind  = KIND_FILL;
                            n_state           = ST_SWEEP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RWAIT: begin
                if (out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                o_ctl.sweep_en = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken result");

    a_sweep_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.sweep_start |=> (r_state == ST_SWEEP))
        else $error("sweep did not start");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_EXEC))
        else $error("accepted request not dispatched");

    a_one_result_per_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> (r_state == ST_EXEC || r_state == ST_RWAIT || r_state == ST_FIN))
        else $error("result produced outside a command");

endmodule

`default_nettype wire

[hw/rtl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, color register, cell store with its sweep counter, and
// the result register of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_wr_en,
    input  wire  [7:0]       i_cfg_wr_data,
    input  wire  [1:0]       i_cmd,
    input  wire  [7:0]       i_char_code,
    input  wire  [4:0]       i_target_row,
    input  wire  [6:0]       i_target_col,
    input  wire tcw_pkg::t_dp_ctl i_ctl,
    output tcw_pkg::t_dp_sts o_sts,
    output logic [39:0]      o_result
);
    import tcw_pkg::*;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;

    logic [1:0]        r_cmd;
    logic [7:0]        r_char;
    logic [ROW_W-1:0]  r_trow;
    logic [COL_W-1:0]  r_tcol;

    logic [7:0]        r_color;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_scroll, n_scroll;
    logic              r_rd_ok;

    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_kind;

    logic [ROW_W-1:0]  r_o_row;
    logic [COL_W-1:0]  r_o_col;
    logic [POS_W-1:0]  r_o_pos;
    logic [15:0]       r_o_entry;
    logic              r_o_scrolled;

    logic              is_nl;
    logic              wrap;
    logic              will_scroll;
    logic              tgt_ok;
    logic [POS_W-1:0]  tgt_pos;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [CNT_W-1:0]  sw_idx;
    logic [15:0]       blank;

    assign is_nl       = (r_char == NEWLINE_CODE);
    assign wrap        = is_nl || (r_col == COL_W'(COLUMNS - 1));
    assign will_scroll = wrap && (r_row == ROW_W'(ROWS - 1));
    assign tgt_ok      = (r_trow < ROW_W'(ROWS)) && (r_tcol < COL_W'(COLUMNS));
    assign tgt_pos     = POS_W'(r_trow) * POS_W'(COLUMNS) + POS_W'(r_tcol);
    assign sw_idx      = r_cnt - CNT_W'(1);
    assign blank       = {(r_kind == KIND_RESET) ? RESET_COLOR : r_color, BLANK_CODE};

    assign o_sts.cmd         = r_cmd;
    assign o_sts.will_scroll = will_scroll;
    assign o_sts.sweep_last  = (r_cnt == CNT_W'(CELLS));

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_pos    = r_pos;
        n_scroll = r_scroll;
        if (i_ctl.do_put) begin
            n_scroll = will_scroll;
            if (will_scroll) begin
                n_row = ROW_W'(ROWS - 1);
                n_col = '0;
                n_pos = POS_W'(COPY);
            end else if (wrap) begin
                n_row = r_row + ROW_W'(1);
                n_col = '0;
                n_pos = r_pos - POS_W'(r_col) + POS_W'(COLUMNS);
            end else begin
                n_col = r_col + COL_W'(1);
                n_pos = r_pos + POS_W'(1);
            end
        end else if (i_ctl.do_set && tgt_ok) begin
            n_row = r_trow;
            n_col = r_tcol;
            n_pos = tgt_pos;
        end else if (i_ctl.do_clear) begin
            n_row = '0;
            n_col = '0;
            n_pos = '0;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(r_pos);
        wr_data = {r_color, r_char};
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(tgt_pos);
        if (i_ctl.do_put && !is_nl) begin
            wr_en = 1'b1;
        end else if (i_ctl.sweep_en) begin
            wr_en   = (r_cnt != '0);
            wr_addr = ADDR_W'(sw_idx);
            if (r_kind == KIND_SCROLL && sw_idx < CNT_W'(COPY)) begin
                wr_data = r_rdata;
            end else begin
                wr_data = blank;
            end
            rd_en   = (r_kind == KIND_SCROLL) && (r_cnt < CNT_W'(COPY));
            rd_addr = ADDR_W'(r_cnt + CNT_W'(COLUMNS));
        end else if (i_ctl.do_read) begin
            rd_en = tgt_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= RESET_COLOR;
            r_row    <= '0;
            r_col    <= '0;
            r_pos    <= '0;
            r_scroll <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_cnt    <= '0;
            r_kind   <= KIND_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            r_row    <= n_row;
            r_col    <= n_col;
            r_pos    <= n_pos;
            r_scroll <= i_ctl.accept ? 1'b0 : n_scroll;
            if (i_ctl.do_read) begin
                r_rd_ok <= tgt_ok;
            end
            if (i_ctl.sweep_start) begin
                r_cnt  <= '0;
                r_kind <= i_ctl.sweep_kind;
            end else if (i_ctl.sweep_en && r_cnt != CNT_W'(CELLS)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= i_cmd;
            r_char <= i_char_code;
            r_trow <= i_target_row;
            r_tcol <= i_target_col;
        end
        if (i_ctl.load_out) begin
            r_o_row      <= n_row;
            r_o_col      <= n_col;
            r_o_pos      <= n_pos;
            r_o_entry    <= (r_cmd == CMD_READ && r_rd_ok) ? r_rdata : 16'h0000;
            r_o_scrolled <= n_scroll;
        end
    end

    assign o_result = {r_o_scrolled, r_o_entry, r_o_pos, r_o_col, r_o_row};

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CELLS))
        else $error("sweep counter out of range");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < ROW_W'(ROWS)) && (r_col < COL_W'(COLUMNS)))
        else $error("cursor left the screen");

    a_pos_tracks_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == POS_W'(r_row) * POS_W'(COLUMNS) + POS_W'(r_col))
        else $error("linear cursor address out of step");

endmodule

`default_nettype wire
